// ----- rtl/core/sog_pkg.sv -----
// Shared types and constants for the speed outlier gate.
// Depends on nothing; every other file of the block but sog_if imports it.
package sog_pkg;

	localparam int SOG_WINDOW = 15;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 30;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ALLOW = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_MIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VAR_MAX       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAD_LIMIT     = 3'd4;

	// Reset values: 2.7 and 0.4 in Q3.12, 0.01 and 0.04 in Q6.24
	localparam logic [14:0] RST_MAX_SPEED     = 15'd11059;
	localparam logic [14:0] RST_REVERSE_ALLOW = 15'd1638;
	localparam logic [29:0] RST_VAR_MIN       = 30'd167772;
	localparam logic [29:0] RST_VAR_MAX       = 30'd671089;
	localparam logic [2:0]  RST_BAD_LIMIT     = 3'd3;

	// Request command codes
	localparam logic CMD_JUDGE = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic [14:0] max_speed;
		logic [14:0] reverse_allow;
		logic [29:0] var_min;
		logic [29:0] var_max;
		logic [2:0]  bad_limit;
	} cfg_t;

	// Sequencer steps handed from the controller to the datapath
	typedef struct packed {
		logic load;
		logic mult;
		logic spread;
		logic clamp;
		logic commit;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SPREAD,
		ST_CLAMP,
		ST_COMMIT
	} state_t;

endpackage

// ----- rtl/core/sog_if.sv -----
// Valid/ready channels for sample requests and verdicts.
// Standalone; payload widths are those of the request and result fields.
interface sog_sample_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] speed;
	logic               direction_known;
	logic               clockwise;

	modport source(output valid, command, speed, direction_known, clockwise, input ready);
	modport sink(input valid, command, speed, direction_known, clockwise, output ready);
endinterface

interface sog_result_if;
	logic valid;
	logic ready;
	logic accepted;
	logic direction_known_out;

	modport source(output valid, accepted, direction_known_out, input ready);
	modport sink(input valid, accepted, direction_known_out, output ready);
endinterface

// ----- rtl/core/sog_ctrl.sv -----
// Sequencer for the speed outlier gate: walks each request through the
// multiply, spread, clamp and commit steps and owns the result valid flag.
// Depends on sog_pkg.
module sog_ctrl
	import sog_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nxt = ST_MUL;
			ST_MUL:    state_nxt = ST_SPREAD;
			ST_SPREAD: state_nxt = ST_CLAMP;
			ST_CLAMP:  state_nxt = ST_COMMIT;
			ST_COMMIT: if (slot_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MUL:    cmd.mult   = 1'b1;
			ST_SPREAD: cmd.spread = 1'b1;
			ST_CLAMP:  cmd.clamp  = 1'b1;
			ST_COMMIT: cmd.commit = slot_free;
			default:   cmd        = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	a_load_reaches_commit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> ##4 (state_q == ST_COMMIT))
		else $error("request did not reach commit four cycles after load");

	a_commit_shows_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("commit did not present a result");

endmodule

// ----- rtl/core/sog_dp.sv -----
// Datapath of the speed outlier gate: window ring memory, running sums,
// range gate, three-sigma test and result register.
// Depends on sog_pkg; stepped by sog_ctrl through cmd_t.
module sog_dp
	import sog_pkg::*;
#(
	parameter int WINDOW = SOG_WINDOW
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	input  cfg_t               cfg,
	input  logic               command,
	input  logic signed [15:0] speed,
	input  logic               direction_known,
	input  logic               clockwise,
	output logic               accepted,
	output logic               direction_known_out
);

	localparam int PTR_W   = $clog2(WINDOW);
	localparam int CNT_W   = $clog2(WINDOW + 1);
	localparam int SUM_W   = 16 + $clog2(WINDOW);
	localparam int SQ_W    = 31 + $clog2(WINDOW);
	localparam int DW      = SUM_W + 2;
	localparam int VW      = 2 * DW;
	localparam int NINE_N  = 9 * WINDOW;
	localparam int NINE_NN = 9 * WINDOW * WINDOW;
	localparam logic signed [DW-1:0] N_S = DW'(WINDOW);

	// request registers
	logic                    cmd_q;
	logic signed [15:0]      x_q;
	logic                    known_q;
	logic                    cw_q;
	logic signed [15:0]      rd_q;

	// window state
	logic signed [15:0]      win_mem [WINDOW];
	logic [CNT_W-1:0]        fill_q;
	logic [PTR_W-1:0]        oldest_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sq_q;
	logic [2:0]              bad_q;

	// step registers
	logic                    gate_q;
	logic [31:0]             xx_q;
	logic [31:0]             oo_q;
	logic [2*SUM_W-1:0]      ss_q;
	logic signed [DW-1:0]    d_q;
	logic [VW-1:0]           ns29_q;
	logic [VW-1:0]           lo9_q;
	logic [VW-1:0]           hi9_q;
	logic [VW-1:0]           vn9_q;
	logic [VW-1:0]           dd_q;
	logic [VW-1:0]           veff9_q;
	logic signed [SUM_W-1:0] sum_fill_q;
	logic signed [SUM_W-1:0] sum_rep_q;
	logic [SQ_W-1:0]         sq_fill_q;
	logic [SQ_W-1:0]         sq_rep_q;

	logic                    acc_q;
	logic                    dir_q;

	// range gate, on the registered sample
	logic signed [16:0] x17;
	logic signed [16:0] mx17;
	logic signed [16:0] rv17;
	logic signed [16:0] hi_lim;
	logic signed [16:0] lo_lim;
	logic               gate_ok;

	always_comb begin
		x17  = 17'(x_q);
		mx17 = signed'({2'b00, cfg.max_speed});
		rv17 = signed'({2'b00, cfg.reverse_allow});
		priority if (!known_q) begin
			hi_lim = mx17;
			lo_lim = -mx17;
		end else if (cw_q) begin
			hi_lim = mx17;
			lo_lim = -rv17;
		end else begin
			hi_lim = rv17;
			lo_lim = -mx17;
		end
		gate_ok = !(x17 > hi_lim || x17 < lo_lim);
	end

	// variance clamp, scaled by 9 on both sides; max clamp applied last
	logic [VW-1:0] clamp_v;

	always_comb begin
		clamp_v = vn9_q;
		if (clamp_v < lo9_q) clamp_v = lo9_q;
		if (clamp_v > hi9_q) clamp_v = hi9_q;
	end

	// commit decision
	logic                    full;
	logic                    sigma_ok;
	logic [3:0]              bad_inc;
	logic [PTR_W-1:0]        oldest_inc;
	logic                    wr_en;
	logic [PTR_W-1:0]        wr_addr;
	logic [CNT_W-1:0]        fill_nxt;
	logic [PTR_W-1:0]        oldest_nxt;
	logic signed [SUM_W-1:0] sum_nxt;
	logic [SQ_W-1:0]         sq_nxt;
	logic [2:0]              bad_nxt;
	logic                    acc_nxt;
	logic                    dir_nxt;

	assign full       = (fill_q == CNT_W'(WINDOW));
	assign sigma_ok   = !(dd_q > veff9_q);
	assign bad_inc    = {1'b0, bad_q} + 4'd1;
	assign oldest_inc = (oldest_q == PTR_W'(WINDOW - 1)) ? '0 : oldest_q + 1'b1;
	assign wr_addr    = full ? oldest_q : fill_q[PTR_W-1:0];

	always_comb begin
		fill_nxt   = fill_q;
		oldest_nxt = oldest_q;
		sum_nxt    = sum_q;
		sq_nxt     = sq_q;
		bad_nxt    = bad_q;
		acc_nxt    = 1'b0;
		dir_nxt    = known_q;
		wr_en      = 1'b0;
		priority if (cmd_q == CMD_CLEAR) begin
			fill_nxt   = '0;
			oldest_nxt = '0;
			sum_nxt    = '0;
			sq_nxt     = '0;
			bad_nxt    = '0;
		end else if (!gate_q || (full && !sigma_ok)) begin
			if (bad_inc > {1'b0, cfg.bad_limit}) begin
				fill_nxt   = '0;
				oldest_nxt = '0;
				sum_nxt    = '0;
				sq_nxt     = '0;
				bad_nxt    = '0;
				dir_nxt    = 1'b0;
			end else begin
				bad_nxt = bad_inc[2:0];
			end
		end else if (!full) begin
			wr_en    = 1'b1;
			fill_nxt = fill_q + 1'b1;
			sum_nxt  = sum_fill_q;
			sq_nxt   = sq_fill_q;
			bad_nxt  = '0;
			acc_nxt  = 1'b1;
		end else begin
			wr_en      = 1'b1;
			oldest_nxt = oldest_inc;
			sum_nxt    = sum_rep_q;
			sq_nxt     = sq_rep_q;
			bad_nxt    = '0;
			acc_nxt    = 1'b1;
		end
	end

	// ring memory: read the oldest entry at load, write at commit
	always_ff @(posedge clk) begin
		if (cmd.commit && wr_en) win_mem[wr_addr] <= x_q;
		if (cmd.load) rd_q <= win_mem[oldest_q];
	end

	// step registers, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q   <= command;
			x_q     <= speed;
			known_q <= direction_known;
			cw_q    <= clockwise;
		end
		if (cmd.mult) begin
			gate_q <= gate_ok;
			xx_q   <= $unsigned(32'(x_q) * 32'(x_q));
			oo_q   <= $unsigned(32'(rd_q) * 32'(rd_q));
			ss_q   <= $unsigned((2*SUM_W)'(sum_q) * (2*SUM_W)'(sum_q));
			d_q    <= DW'(x_q) * N_S - DW'(sum_q);
			ns29_q <= VW'(sq_q) * VW'(NINE_N);
			lo9_q  <= VW'(cfg.var_min) * VW'(NINE_NN);
			hi9_q  <= VW'(cfg.var_max) * VW'(NINE_NN);
		end
		if (cmd.spread) begin
			vn9_q      <= ns29_q - VW'(ss_q) - (VW'(ss_q) << 3);
			dd_q       <= $unsigned(VW'(d_q) * VW'(d_q));
			sum_fill_q <= sum_q + SUM_W'(x_q);
			sum_rep_q  <= sum_q + SUM_W'(x_q) - SUM_W'(rd_q);
			sq_fill_q  <= sq_q + SQ_W'(xx_q);
			sq_rep_q   <= sq_q + SQ_W'(xx_q) - SQ_W'(oo_q);
		end
		if (cmd.clamp) veff9_q <= clamp_v;
		if (cmd.commit) begin
			acc_q <= acc_nxt;
			dir_q <= dir_nxt;
		end
	end

	// window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			oldest_q <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			bad_q    <= '0;
		end else if (cmd.commit) begin
			fill_q   <= fill_nxt;
			oldest_q <= oldest_nxt;
			sum_q    <= sum_nxt;
			sq_q     <= sq_nxt;
			bad_q    <= bad_nxt;
		end
	end

	assign accepted            = acc_q;
	assign direction_known_out = dir_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(WINDOW))
		else $error("fill count beyond window depth");

	a_empty_sums_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0) |-> (sum_q == '0 && sq_q == '0))
		else $error("empty window with nonzero sums");

	a_ring_moves_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q != '0) |-> full)
		else $error("ring pointer moved before the window filled");

	// n*S2 - S^2 is never negative for consistent sums
	a_spread_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clamp |-> !vn9_q[VW-1])
		else $error("window spread went negative");

endmodule

// ----- rtl/core/speed_outlier_gate.sv -----
// Top level of the speed outlier gate: configuration registers, sequencer
// and datapath. Depends on sog_pkg, sog_if, sog_ctrl and sog_dp.
//
//  channel   dir  handshake          payload
//  samples   in   valid/ready        command, speed, direction_known, clockwise
//  results   out  valid/ready        accepted, direction_known_out
//  cfg       in   cfg_we (no ready)  cfg_index, cfg_data
//
// After the load, a request passes through the four-step sequencer (multiply,
// spread, clamp, commit) on its way to a registered result.
// One request is in flight at a time; the next is taken once the last has committed.
// A waiting result does not block acceptance; only the commit step holds
// while the result register is still full and not taken.
// Reset restores the register defaults and empties the window at once.
module speed_outlier_gate
	import sog_pkg::*;
#(
	parameter int WINDOW = SOG_WINDOW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	sog_sample_if.sink            samples,
	sog_result_if.source          results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_speed     <= RST_MAX_SPEED;
			cfg_q.reverse_allow <= RST_REVERSE_ALLOW;
			cfg_q.var_min       <= RST_VAR_MIN;
			cfg_q.var_max       <= RST_VAR_MAX;
			cfg_q.bad_limit     <= RST_BAD_LIMIT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_SPEED:     cfg_q.max_speed     <= cfg_data[14:0];
				REG_REVERSE_ALLOW: cfg_q.reverse_allow <= cfg_data[14:0];
				REG_VAR_MIN:       cfg_q.var_min       <= cfg_data;
				REG_VAR_MAX:       cfg_q.var_max       <= cfg_data;
				REG_BAD_LIMIT:     cfg_q.bad_limit     <= cfg_data[2:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	sog_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd)
	);

	sog_dp #(
		.WINDOW (WINDOW)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.cfg                 (cfg_q),
		.command             (samples.command),
		.speed               (samples.speed),
		.direction_known     (samples.direction_known),
		.clockwise           (samples.clockwise),
		.accepted            (results.accepted),
		.direction_known_out (results.direction_known_out)
	);

endmodule

// ----- tb/speed_outlier_gate_checker.sv -----
// Checker for the speed outlier gate: watches the request, result and
// configuration ports, predicts each verdict and compares it in order.
// Depends on sog_pkg and sog_if.
module speed_outlier_gate_checker
	import sog_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	sog_sample_if                 samples,
	sog_result_if                 results,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    outstanding
);

	typedef struct packed {
		logic accepted;
		logic direction_known_out;
	} verdict_t;

	verdict_t           verdict_q[$];
	cfg_t               cfg;
	logic signed [15:0] ring [SOG_WINDOW];
	int                 fill;
	int                 head;
	int                 bad_cnt;
	longint             win_sum;
	longint             win_sq;
	int                 n_req;
	int                 n_res;

	assign outstanding = n_req - n_res;

	function automatic void empty_window();
		fill    = 0;
		head    = 0;
		bad_cnt = 0;
		win_sum = 0;
		win_sq  = 0;
	endfunction

	// returns 1 when the rejection flushes the window
	function automatic logic count_reject();
		if (bad_cnt + 1 > int'(cfg.bad_limit)) begin
			empty_window();
			return 1'b1;
		end
		bad_cnt = bad_cnt + 1;
		return 1'b0;
	endfunction

	function automatic logic in_range(int x, logic known, logic cw);
		int mx;
		int rv;
		mx = int'(cfg.max_speed);
		rv = int'(cfg.reverse_allow);
		if (!known)
			return !(x > mx || x < -mx);
		if (cw)
			return !(x > mx || x < -rv);
		return !(x < -mx || x > rv);
	endfunction

	// (n*x - S)^2 > 9 * clamp(n*S2 - S^2), all scaled by n^2 so nothing rounds
	function automatic logic within_spread(int x);
		longint n;
		longint vn;
		longint lo;
		longint hi;
		longint d;
		n  = longint'(SOG_WINDOW);
		vn = n * win_sq - win_sum * win_sum;
		lo = longint'(cfg.var_min) * n * n;
		hi = longint'(cfg.var_max) * n * n;
		if (vn < lo)
			vn = lo;
		if (vn > hi)
			vn = hi;
		d = n * longint'(x) - win_sum;
		return !(d * d > 9 * vn);
	endfunction

	function automatic verdict_t judge_sample(logic cmd, logic signed [15:0] spd,
			logic known, logic cw);
		verdict_t v;
		int       x;
		int       slot;
		x = int'(spd);
		v.accepted = 1'b0;
		v.direction_known_out = known;
		if (cmd == CMD_CLEAR) begin
			empty_window();
		end else if (!in_range(x, known, cw)) begin
			if (count_reject())
				v.direction_known_out = 1'b0;
		end else if (fill < SOG_WINDOW) begin
			slot = (head + fill) % SOG_WINDOW;
			ring[slot] = spd;
			fill = fill + 1;
			win_sum = win_sum + x;
			win_sq = win_sq + longint'(x) * x;
			bad_cnt = 0;
			v.accepted = 1'b1;
		end else if (!within_spread(x)) begin
			if (count_reject())
				v.direction_known_out = 1'b0;
		end else begin
			win_sum = win_sum + x - ring[head];
			win_sq = win_sq + longint'(x) * x - longint'(ring[head]) * ring[head];
			ring[head] = spd;
			head = (head + 1) % SOG_WINDOW;
			bad_cnt = 0;
			v.accepted = 1'b1;
		end
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		verdict_t exp_v;
		int       bad_fields;
		if (!arst_n) begin
			cfg.max_speed     = RST_MAX_SPEED;
			cfg.reverse_allow = RST_REVERSE_ALLOW;
			cfg.var_min       = RST_VAR_MIN;
			cfg.var_max       = RST_VAR_MAX;
			cfg.bad_limit     = RST_BAD_LIMIT;
			empty_window();
			verdict_q.delete();
			errors <= 0;
			n_req  <= 0;
			n_res  <= 0;
		end else begin
			bad_fields = 0;
			if (results.valid && results.ready) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual accepted=%0b dir=%0b",
						$time, results.accepted, results.direction_known_out);
					bad_fields = bad_fields + 1;
				end else begin
					exp_v = verdict_q.pop_front();
					if (results.accepted !== exp_v.accepted) begin
						$display("%0t: accepted mismatch, expected %0b actual %0b",
							$time, exp_v.accepted, results.accepted);
						bad_fields = bad_fields + 1;
					end
					if (results.direction_known_out !== exp_v.direction_known_out) begin
						$display("%0t: direction_known_out mismatch, expected %0b actual %0b",
							$time, exp_v.direction_known_out, results.direction_known_out);
						bad_fields = bad_fields + 1;
					end
					n_res <= n_res + 1;
				end
			end
			errors <= errors + bad_fields;

			if (cfg_we) begin
				case (cfg_index)
					REG_MAX_SPEED:     cfg.max_speed     = cfg_data[14:0];
					REG_REVERSE_ALLOW: cfg.reverse_allow = cfg_data[14:0];
					REG_VAR_MIN:       cfg.var_min       = cfg_data[29:0];
					REG_VAR_MAX:       cfg.var_max       = cfg_data[29:0];
					REG_BAD_LIMIT:     cfg.bad_limit     = cfg_data[2:0];
					default: ;
				endcase
			end

			if (samples.valid && samples.ready) begin
				verdict_q = {verdict_q, judge_sample(samples.command, samples.speed,
					samples.direction_known, samples.clockwise)};
				n_req <= n_req + 1;
			end
		end
	end

endmodule

// ----- tb/speed_outlier_gate_tb.sv -----
// Testbench top for the speed outlier gate: clock, reset, request and
// configuration stimulus, result-side stalls and the verdict.
// Depends on sog_pkg, sog_if, speed_outlier_gate and speed_outlier_gate_checker.
module speed_outlier_gate_tb;
	import sog_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	// index past the register list; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	bit                    idle_en = 1'b1;
	bit                    hold_go = 1'b0;
	bit                    hold_off = 1'b0;
	bit                    sink_ready = 1'b0;
	int                    cycle_cnt = 0;
	int                    cur_max = int'(RST_MAX_SPEED);
	int                    errors;
	int                    outstanding;

	sog_sample_if samples_ch ();
	sog_result_if results_ch ();

	assign results_ch.ready = sink_ready;

	speed_outlier_gate u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples_ch),
		.results   (results_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	speed_outlier_gate_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples_ch),
		.results     (results_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk)
		sink_ready <= !hold_off && !(idle_en && $urandom_range(0, 99) < 25);

	// long result-side stall so the block backs up into its input
	initial begin
		wait (hold_go);
		repeat (40) @(posedge clk);
		hold_off <= 1'b1;
		repeat (150) @(posedge clk);
		hold_off <= 1'b0;
	end

	function automatic logic signed [15:0] sat16(int x);
		if (x > 32767)
			return 16'sd32767;
		if (x < -32768)
			return -16'sd32768;
		return 16'(x);
	endfunction

	// valid stays high from one request to the next unless a gap is taken
	task automatic send_req(logic cmd, logic signed [15:0] spd, logic known, logic cw);
		while (idle_en && $urandom_range(0, 99) < 25) begin
			samples_ch.valid <= 1'b0;
			@(posedge clk);
		end
		samples_ch.valid           <= 1'b1;
		samples_ch.command         <= cmd;
		samples_ch.speed           <= spd;
		samples_ch.direction_known <= known;
		samples_ch.clockwise       <= cw;
		@(posedge clk);
		while (!samples_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_idle();
		samples_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// upper data bits beyond a register's width are left as given
	task automatic load_config(logic [CFG_DATA_W-1:0] ms, logic [CFG_DATA_W-1:0] ra,
			logic [CFG_DATA_W-1:0] vlo, logic [CFG_DATA_W-1:0] vhi,
			logic [CFG_DATA_W-1:0] bl);
		cfg_put(REG_MAX_SPEED, ms);
		cfg_put(REG_REVERSE_ALLOW, ra);
		cfg_put(REG_VAR_MIN, vlo);
		cfg_put(REG_VAR_MAX, vhi);
		cfg_put(REG_BAD_LIMIT, bl);
		cfg_we  <= 1'b0;
		cur_max = int'(ms[14:0]);
	endtask

	// bursts of samples around a steady speed, with outliers, clears and noise
	task automatic run_phase(int n_items);
		int   sent;
		int   len;
		int   base;
		int   amp;
		int   pick;
		logic known;
		logic cw;
		sent = 0;
		while (sent < n_items) begin
			len  = $urandom_range(8, 40);
			base = int'($urandom_range(0, 2 * cur_max)) - cur_max;
			case ($urandom_range(0, 3))
				0: amp = 64;
				1: amp = 600;
				2: amp = 1500;
				default: amp = 4000;
			endcase
			known = ($urandom_range(0, 3) != 0);
			cw    = (base >= 0) ^ ($urandom_range(0, 9) == 0);
			for (int i = 0; i < len && sent < n_items; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 85)
					send_req(CMD_JUDGE, sat16(base + int'($urandom_range(0, 2 * amp)) - amp),
						known, cw);
				else if (pick < 92)
					send_req(CMD_JUDGE, sat16(base + ($urandom_range(0, 1) ? 1 : -1) *
						(3 * amp + int'($urandom_range(0, 3000)))), known, cw);
				else if (pick < 95)
					send_req(CMD_CLEAR, 16'($urandom), 1'($urandom), 1'($urandom));
				else
					send_req($urandom_range(0, 1) ? CMD_CLEAR : CMD_JUDGE, 16'($urandom),
						1'($urandom), 1'($urandom));
				sent = sent + 1;
			end
		end
	endtask

	initial begin
		samples_ch.valid           <= 1'b0;
		samples_ch.command         <= CMD_JUDGE;
		samples_ch.speed           <= '0;
		samples_ch.direction_known <= 1'b0;
		samples_ch.clockwise       <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// gate edges at reset limits, then a run of rejections ended by a clear
		send_req(CMD_JUDGE, 16'sd11059, 1'b0, 1'b0);
		send_req(CMD_JUDGE, 16'sd11060, 1'b0, 1'b0);
		send_req(CMD_JUDGE, -16'sd11059, 1'b0, 1'b1);
		send_req(CMD_JUDGE, -16'sd1638, 1'b1, 1'b1);
		send_req(CMD_JUDGE, -16'sd1639, 1'b1, 1'b1);
		send_req(CMD_JUDGE, 16'sd1638, 1'b1, 1'b0);
		send_req(CMD_JUDGE, 16'sd1639, 1'b1, 1'b0);
		send_req(CMD_JUDGE, 16'sd32767, 1'b0, 1'b1);
		send_req(CMD_JUDGE, -16'sd32768, 1'b1, 1'b1);
		send_req(CMD_CLEAR, 16'sd32767, 1'b1, 1'b1);

		// full window of near-equal samples: variance held up by var_min
		for (int i = 0; i < SOG_WINDOW; i++)
			send_req(CMD_JUDGE, 16'(4096 + 8 * i), 1'b1, 1'b1);
		send_req(CMD_JUDGE, 16'sd4200, 1'b1, 1'b1);
		send_req(CMD_JUDGE, 16'sd8000, 1'b1, 1'b1);
		send_req(CMD_JUDGE, 16'sd8000, 1'b1, 1'b1);

		// bad count of two, limit dropped below it: next rejection flushes
		wait_idle();
		cfg_put(REG_BAD_LIMIT, '0);
		cfg_we <= 1'b0;
		send_req(CMD_JUDGE, 16'sd8000, 1'b1, 1'b1);

		wait_idle();
		load_config(30'(RST_MAX_SPEED), 30'(RST_REVERSE_ALLOW), RST_VAR_MIN, RST_VAR_MAX,
			30'(RST_BAD_LIMIT));
		hold_go <= 1'b1;
		run_phase(140);

		// widest settings; masked down to every register's maximum
		wait_idle();
		load_config('1, '1, '1, '1, '1);
		run_phase(140);

		wait_idle();
		load_config('0, '0, '0, '0, '0);
		run_phase(60);

		// a long stretch with no gaps on either side
		wait_idle();
		idle_en <= 1'b0;
		load_config(30'($urandom_range(4096, 20000)), 30'($urandom_range(0, 8000)),
			30'($urandom_range(0, 1000000)), 30'($urandom_range(1000000, 8000000)),
			30'($urandom_range(0, 7)));
		run_phase(200);

		// crossed clamps: var_min above var_max
		wait_idle();
		idle_en <= 1'b1;
		load_config(30'(RST_MAX_SPEED), 30'(RST_REVERSE_ALLOW), 30'd2684354, RST_VAR_MIN,
			30'(RST_BAD_LIMIT));
		run_phase(140);

		wait_idle();
		cfg_put(REG_UNUSED, 30'($urandom));
		load_config(30'($urandom), 30'($urandom), 30'($urandom), 30'($urandom),
			30'($urandom));
		run_phase(160);

		wait_idle();
		if (errors == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
